### rtl/rmt_pkg.sv
// shared constants, cell operation codes and chain control type for the running median tracker
`timescale 1ns / 1ps

package rmt_pkg;

  // number of samples the tracker can hold
  localparam int CAPACITY = 1024;

  // each half of the store is a chain of cells; the lower half holds the extra one
  localparam int CHAIN_DEPTH = (CAPACITY + 1) / 2;
  localparam int IDX_W = (CHAIN_DEPTH > 1) ? $clog2(CHAIN_DEPTH) : 1;
  localparam int SIZE_W = $clog2(CHAIN_DEPTH + 1);
  localparam int TOTAL_W = SIZE_W + 1;

  // field widths
  localparam int SAMPLE_W = 32;
  localparam int MEDIAN_W = 33;
  localparam int COUNT_W = 11;

  // operation broadcast to every cell of a chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'b00,
    OP_INSERT = 2'b01,
    OP_POP    = 2'b10
  } cell_op_t;

  // control that a chain receives each cycle
  typedef struct packed {
    cell_op_t                    op;
    logic signed [SAMPLE_W-1:0]  operand;
    logic        [SIZE_W-1:0]    size;
  } chain_ctrl_t;

endpackage

### rtl/running_median_tracker.sv
// running median tracker: two sorted cell chains holding the lower and upper halves
//
//   channel   direction  payload                              handshake
//   sample    in         sample                               sample_valid / sample_stall
//   result    out        median_twice, kept_count, dropped    result_valid / result_stall
//
// a request passes the insert state when it goes straight into its half, and a move state
// before it when the head of one chain must first move to the other to keep the halves
// balanced; a full store skips both. A chain performs one insert or shift per cycle
// the result is registered; sample_stall stays high from acceptance until the result
// enters the output register, which waits while result_stall holds a previous result
// rst is synchronous and empties both chains; cell contents need no clearing
`timescale 1ns / 1ps

module running_median_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic signed [rmt_pkg::SAMPLE_W-1:0] sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic signed [rmt_pkg::MEDIAN_W-1:0] median_twice,
  output logic        [rmt_pkg::COUNT_W-1:0]  kept_count,
  output logic                                dropped
);
  import rmt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_MOVE   = 4'b0010,
    S_INSERT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                     state;
  state_t                     state_next;
  logic        [SIZE_W-1:0]   lo_size;
  logic        [SIZE_W-1:0]   hi_size;
  logic        [SIZE_W-1:0]   lo_size_next;
  logic        [SIZE_W-1:0]   hi_size_next;
  logic                       to_lo;
  logic                       to_lo_next;
  logic                       drop;
  logic                       drop_next;
  logic signed [SAMPLE_W-1:0] held_sample;
  logic                       result_valid_next;
  logic                       load_result;
  logic                       accept;

  chain_ctrl_t                lo_ctrl;
  chain_ctrl_t                hi_ctrl;
  logic signed [SAMPLE_W-1:0] lo_raw;
  logic signed [SAMPLE_W-1:0] lo_head;
  logic signed [SAMPLE_W-1:0] hi_head;
  logic        [TOTAL_W-1:0]  total;
  logic                       even;
  logic                       full;
  logic signed [MEDIAN_W-1:0] median_calc;

  // lower half is stored inverted so that both chains sort ascending
  rmt_chain u_lo_chain (
    .clk  (clk),
    .ctrl (lo_ctrl),
    .head (lo_raw)
  );

  rmt_chain u_hi_chain (
    .clk  (clk),
    .ctrl (hi_ctrl),
    .head (hi_head)
  );

  assign lo_head = ~lo_raw;
  assign total   = {1'b0, lo_size} + {1'b0, hi_size};
  assign even    = (lo_size == hi_size);
  assign full    = total >= TOTAL_W'(CAPACITY);

  // handshake
  assign sample_stall = rst || (state != S_IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign load_result  = (state == S_RESULT) && (!result_valid || !result_stall);

  // twice the median from the two chain heads
  always_comb begin
    if (even) begin
      median_calc = {lo_head[SAMPLE_W-1], lo_head} + {hi_head[SAMPLE_W-1], hi_head};
    end else begin
      median_calc = {lo_head, 1'b0};
    end
  end

  // sequencer and chain control
  always_comb begin
    state_next        = state;
    lo_size_next      = lo_size;
    hi_size_next      = hi_size;
    to_lo_next        = to_lo;
    drop_next         = drop;
    result_valid_next = result_valid && result_stall;
    lo_ctrl.op        = OP_HOLD;
    lo_ctrl.operand   = ~held_sample;
    lo_ctrl.size      = lo_size;
    hi_ctrl.op        = OP_HOLD;
    hi_ctrl.operand   = held_sample;
    hi_ctrl.size      = hi_size;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (full) begin
            drop_next  = 1'b1;
            state_next = S_RESULT;
          end else begin
            drop_next = 1'b0;
            if (even) begin
              // lower half grows: move the upper head down if the sample belongs above it
              if (total == '0 || sample <= hi_head) begin
                to_lo_next = 1'b1;
                state_next = S_INSERT;
              end else begin
                to_lo_next = 1'b0;
                state_next = S_MOVE;
              end
            end else begin
              // upper half grows: move the lower head up if the sample belongs below it
              if (sample >= lo_head) begin
                to_lo_next = 1'b0;
                state_next = S_INSERT;
              end else begin
                to_lo_next = 1'b1;
                state_next = S_MOVE;
              end
            end
          end
        end
      end
      S_MOVE: begin
        if (to_lo) begin
          lo_ctrl.op      = OP_POP;
          hi_ctrl.op      = OP_INSERT;
          hi_ctrl.operand = lo_head;
          lo_size_next    = lo_size - 1'b1;
          hi_size_next    = hi_size + 1'b1;
        end else begin
          hi_ctrl.op      = OP_POP;
          lo_ctrl.op      = OP_INSERT;
          lo_ctrl.operand = ~hi_head;
          hi_size_next    = hi_size - 1'b1;
          lo_size_next    = lo_size + 1'b1;
        end
        state_next = S_INSERT;
      end
      S_INSERT: begin
        if (to_lo) begin
          lo_ctrl.op   = OP_INSERT;
          lo_size_next = lo_size + 1'b1;
        end else begin
          hi_ctrl.op   = OP_INSERT;
          hi_size_next = hi_size + 1'b1;
        end
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (load_result) begin
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      lo_size      <= '0;
      hi_size      <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      lo_size      <= lo_size_next;
      hi_size      <= hi_size_next;
      result_valid <= result_valid_next;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    to_lo <= to_lo_next;
    drop  <= drop_next;
    if (accept) begin
      held_sample <= sample;
    end
    if (load_result) begin
      median_twice <= median_calc;
      kept_count   <= COUNT_W'(total);
      dropped      <= drop;
    end
  end

endmodule

### rtl/rmt_cell.sv
// one cell of a sorted chain: holds a value, inserts in order or shifts toward the head
`timescale 1ns / 1ps

module rmt_cell (
  input  logic                                clk,
  input  rmt_pkg::chain_ctrl_t                ctrl,
  input  logic [rmt_pkg::IDX_W-1:0]           index,
  input  logic                                left_keep,
  input  logic signed [rmt_pkg::SAMPLE_W-1:0] left_value,
  input  logic signed [rmt_pkg::SAMPLE_W-1:0] right_value,
  output logic                                keep,
  output logic signed [rmt_pkg::SAMPLE_W-1:0] value
);
  import rmt_pkg::*;

  logic                       occupied;
  logic signed [SAMPLE_W-1:0] value_next;

  // cell holds a live entry when it lies below the chain fill
  assign occupied = SIZE_W'(index) < ctrl.size;

  // entries not above the operand stay where they are
  assign keep = occupied && (value <= ctrl.operand);

  // next value from operation and neighbors
  always_comb begin
    unique case (ctrl.op)
      OP_INSERT: begin
        if (keep) begin
          value_next = value;
        end else if (left_keep) begin
          value_next = ctrl.operand;
        end else begin
          value_next = left_value;
        end
      end
      OP_POP:  value_next = right_value;
      default: value_next = value;
    endcase
  end

  // value register
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

### rtl/rmt_chain.sv
// ascending chain of cells with its smallest entry at the head
`timescale 1ns / 1ps

module rmt_chain (
  input  logic                                clk,
  input  rmt_pkg::chain_ctrl_t                ctrl,
  output logic signed [rmt_pkg::SAMPLE_W-1:0] head
);
  import rmt_pkg::*;

  logic                       keep  [0:CHAIN_DEPTH-1];
  logic signed [SAMPLE_W-1:0] value [0:CHAIN_DEPTH-1];

  // row of cells, each linked to both neighbors
  for (genvar i = 0; i < CHAIN_DEPTH; i++) begin : g_cell
    logic                       left_keep;
    logic signed [SAMPLE_W-1:0] left_value;
    logic signed [SAMPLE_W-1:0] right_value;

    if (i == 0) begin : g_head
      assign left_keep  = 1'b1;
      assign left_value = ctrl.operand;
    end else begin : g_body
      assign left_keep  = keep[i-1];
      assign left_value = value[i-1];
    end

    if (i == CHAIN_DEPTH - 1) begin : g_tail
      assign right_value = value[i];
    end else begin : g_inner
      assign right_value = value[i+1];
    end

    rmt_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .index       (IDX_W'(i)),
      .left_keep   (left_keep),
      .left_value  (left_value),
      .right_value (right_value),
      .keep        (keep[i]),
      .value       (value[i])
    );
  end

  assign head = value[0];

endmodule

### rtl/rmt_checker.sv
// port-level checks for the running median tracker and their bind
`timescale 1ns / 1ps

module rmt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_valid,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input logic signed [rmt_pkg::MEDIAN_W-1:0] median_twice,
  input logic        [rmt_pkg::COUNT_W-1:0]  kept_count,
  input logic                                dropped
);
  import rmt_pkg::*;

  // a stalled result holds its payload
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(median_twice) && $stable(kept_count) && $stable(dropped))
    else $error("stalled result changed");

  // one request at a time: an accepted sample blocks the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample accepted while previous request in flight");

  // a dropped sample only happens with a full store
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && dropped |-> kept_count == COUNT_W'(CAPACITY))
    else $error("sample dropped below capacity");

  // odd count gives a whole median, so no fraction bit
  a_odd_whole: assert property (@(posedge clk) disable iff (rst)
    result_valid && kept_count[0] |-> !median_twice[0])
    else $error("fraction bit set with odd count");

endmodule

bind running_median_tracker rmt_checker u_rmt_checker (.*);
